@@ sv/msc_pkg.sv @@
// Shared types and constants of the motorized shutter controller.
package msc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 32;

  localparam logic [TIME_W-1:0] RUN_TIMEOUT_RST = 32'd60000;

  typedef enum logic [0:0] {
    CFG_RUN_TIMEOUT = 1'b0,
    CFG_INTER_MODE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_OPEN  = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_ABORT = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_SHUT    = 3'd0,
    ST_OPEN    = 3'd1,
    ST_GO_OPEN = 3'd2,
    ST_GO_SHUT = 3'd3,
    ST_HALTED  = 3'd4,
    ST_FAULT   = 3'd5,
    ST_UNINIT  = 3'd7
  } state_e;

  typedef enum logic [1:0] {
    MOTOR_KEEP  = 2'd0,
    MOTOR_RUN   = 2'd1,
    MOTOR_BRAKE = 2'd2
  } motor_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_INNER = 2'd1,
    MODE_OUTER = 2'd2
  } inter_mode_e;

  localparam logic DIR_TO_OPEN  = 1'b0;
  localparam logic DIR_TO_CLOSE = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              sw_closed;
    logic              sw_open;
    logic              sw_inter;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] shutter_state;
    logic [1:0] motor_cmd;
    logic       motor_dir;
  } result_t;

  // controller state handed between the top level and the step logic
  typedef struct packed {
    state_e            state;
    logic [TIME_W-1:0] move_start_ms;
  } ctrl_t;

  typedef struct packed {
    logic [TIME_W-1:0] run_timeout_ms;
    logic [1:0]        inter_mode;
  } cfg_t;

endpackage

@@ sv/msc_if.sv @@
// Valid/ready channel interfaces for tick items and results.
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        sw_closed;
  logic        sw_open;
  logic        sw_inter;
  logic [31:0] now_ms;

  modport source (output valid, req_type, sw_closed, sw_open, sw_inter, now_ms,
                  input ready);
  modport sink   (input valid, req_type, sw_closed, sw_open, sw_inter, now_ms,
                  output ready);
endinterface

interface msc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] shutter_state;
  logic [1:0] motor_cmd;
  logic       motor_dir;

  modport source (output valid, shutter_state, motor_cmd, motor_dir, input ready);
  modport sink   (input valid, shutter_state, motor_cmd, motor_dir, output ready);
endinterface

@@ sv/motorized_shutter_controller.sv @@
// Top level of the motorized shutter controller.
//
//   channel | dir | transfer when  | payload
//   --------+-----+----------------+---------------------------------------------
//   in_i    | in  | valid && ready | req_type, sw_closed, sw_open, sw_inter, now_ms
//   out_o   | out | valid && ready | shutter_state, motor_cmd, motor_dir
//   cfg     | in  | cfg_we_i       | cfg_idx_i, cfg_data_i
//
// One tick per cycle sustained while out_o is not stalled; a result passes the tick
// register, then the result register, the step logic sitting between the two.
// Reset clears control and sets the configuration to its defaults; the shutter state
// starts uninitialized and the first tick seeds it from the limit switches.
// A stalled result holds the tick register, and in_i.ready drops only when both
// stages are full.
module motorized_shutter_controller (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  msc_in_if.sink                    in_i,
  msc_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  msc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [msc_pkg::CFG_W-1:0] cfg_data_i
);
  import msc_pkg::*;

  logic    tick_valid_q;
  item_t   tick_q;
  logic    out_valid_q;
  result_t out_q;
  ctrl_t   ctrl_q, ctrl_d;
  cfg_t    cfg_q;
  result_t res_d;
  logic    out_free;
  logic    tick_adv;
  logic    in_xfer;

  assign out_free = !out_valid_q || out_o.ready;
  assign tick_adv = tick_valid_q && out_free;
  assign in_i.ready = !tick_valid_q || out_free;
  assign in_xfer = in_i.valid && in_i.ready;

  msc_step u_step (
    .ctrl_i (ctrl_q),
    .cfg_i  (cfg_q),
    .item_i (tick_q),
    .ctrl_o (ctrl_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_timeout_ms <= RUN_TIMEOUT_RST;
      cfg_q.inter_mode     <= MODE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RUN_TIMEOUT: cfg_q.run_timeout_ms <= cfg_data_i;
        CFG_INTER_MODE:  cfg_q.inter_mode     <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ctrl_q.state         <= ST_UNINIT;
      ctrl_q.move_start_ms <= '0;
    end else begin
      if (in_i.ready) tick_valid_q <= in_i.valid;
      if (out_free)   out_valid_q  <= tick_valid_q;
      // commit the state only as the tick moves to the result register
      if (tick_adv)   ctrl_q       <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q.req_type  <= in_i.req_type;
      tick_q.sw_closed <= in_i.sw_closed;
      tick_q.sw_open   <= in_i.sw_open;
      tick_q.sw_inter  <= in_i.sw_inter;
      tick_q.now_ms    <= in_i.now_ms;
    end
    if (tick_adv) out_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.shutter_state = out_q.shutter_state;
  assign out_o.motor_cmd     = out_q.motor_cmd;
  assign out_o.motor_dir     = out_q.motor_dir;

endmodule

@@ sv/msc_step.sv @@
// Per-tick state update and motor command logic.
module msc_step (
  input  msc_pkg::ctrl_t   ctrl_i,
  input  msc_pkg::cfg_t    cfg_i,
  input  msc_pkg::item_t   item_i,
  output msc_pkg::ctrl_t   ctrl_o,
  output msc_pkg::result_t res_o
);
  import msc_pkg::*;

  state_e            st;
  logic              to_open;
  logic              held;
  logic              target_sw;
  logic [TIME_W-1:0] elapsed;
  motor_e            cmd;
  logic              dir;
  req_e              req;

  assign req     = req_e'(item_i.req_type);
  assign elapsed = item_i.now_ms - ctrl_i.move_start_ms;

  // seed the state from the switches on the first tick after reset
  always_comb begin
    if (ctrl_i.state == ST_UNINIT) begin
      if (item_i.sw_closed)    st = ST_SHUT;
      else if (item_i.sw_open) st = ST_OPEN;
      else                     st = ST_HALTED;
    end else begin
      st = ctrl_i.state;
    end
  end

  assign to_open   = (st == ST_GO_OPEN);
  assign target_sw = to_open ? item_i.sw_open : item_i.sw_closed;
  assign held      = to_open
                   ? ((cfg_i.inter_mode == MODE_INNER) && item_i.sw_inter)
                   : ((cfg_i.inter_mode == MODE_OUTER) && !item_i.sw_inter);

  always_comb begin
    ctrl_o.state         = st;
    ctrl_o.move_start_ms = ctrl_i.move_start_ms;
    cmd                  = MOTOR_KEEP;
    dir                  = DIR_TO_OPEN;
    unique case (st)
      ST_SHUT: begin
        if (req == REQ_OPEN) begin
          ctrl_o.state         = ST_GO_OPEN;
          ctrl_o.move_start_ms = item_i.now_ms;
        end
      end
      ST_OPEN: begin
        if (req == REQ_CLOSE) begin
          ctrl_o.state         = ST_GO_SHUT;
          ctrl_o.move_start_ms = item_i.now_ms;
        end
      end
      ST_HALTED, ST_FAULT: begin
        if (req == REQ_OPEN) begin
          ctrl_o.state         = ST_GO_OPEN;
          ctrl_o.move_start_ms = item_i.now_ms;
        end else if (req == REQ_CLOSE) begin
          ctrl_o.state         = ST_GO_SHUT;
          ctrl_o.move_start_ms = item_i.now_ms;
        end
      end
      ST_GO_OPEN, ST_GO_SHUT: begin
        // end of move wins over interference hold
        if (target_sw) begin
          ctrl_o.state = to_open ? ST_OPEN : ST_SHUT;
          cmd          = MOTOR_BRAKE;
        end else if (req == REQ_ABORT) begin
          ctrl_o.state = ST_HALTED;
          cmd          = MOTOR_BRAKE;
        end else if (elapsed > cfg_i.run_timeout_ms) begin
          ctrl_o.state = ST_FAULT;
          cmd          = MOTOR_BRAKE;
        end else if (held) begin
          cmd = MOTOR_BRAKE;
        end else begin
          cmd = MOTOR_RUN;
          dir = to_open ? DIR_TO_OPEN : DIR_TO_CLOSE;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.shutter_state = ctrl_o.state;
  assign res_o.motor_cmd     = cmd;
  assign res_o.motor_dir     = dir;

endmodule

@@ sv/msc_checker.sv @@
// Port-level checks for the motorized shutter controller, bound to the top level.
module msc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] shutter_state_i,
  input logic [1:0] motor_cmd_i,
  input logic       motor_dir_i
);
  import msc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(shutter_state_i)
                                    && $stable(motor_cmd_i) && $stable(motor_dir_i))
    else $error("result changed while stalled");

  a_run_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && motor_cmd_i == MOTOR_RUN |->
      shutter_state_i == ST_GO_OPEN || shutter_state_i == ST_GO_SHUT)
    else $error("motor runs outside a move");

  a_dir_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && motor_dir_i |->
      motor_cmd_i == MOTOR_RUN && shutter_state_i == ST_GO_SHUT)
    else $error("close direction without closing run");

  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> shutter_state_i != ST_UNINIT && shutter_state_i != 3'd6
                    && motor_cmd_i != 2'd3)
    else $error("result carries an unused code");

endmodule

bind motorized_shutter_controller msc_checker u_msc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .shutter_state_i (out_o.shutter_state),
  .motor_cmd_i     (out_o.motor_cmd),
  .motor_dir_i     (out_o.motor_dir)
);

@@ tb/motorized_shutter_controller_tb.sv @@
// Testbench for the motorized shutter controller: directed and random ticks, results checked.
`timescale 1ns / 100ps

module motorized_shutter_controller_tb;
  import msc_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  cfg_idx_e          cfg_idx;
  logic [CFG_W-1:0]  cfg_data;

  msc_in_if  tick_if ();
  msc_out_if result_if ();

  motorized_shutter_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow of the controller
  state_e            shut_state  = ST_UNINIT;
  logic [TIME_W-1:0] move_t0     = '0;
  logic [TIME_W-1:0] cfg_timeout = RUN_TIMEOUT_RST;
  logic [1:0]        cfg_mode    = MODE_NONE;

  result_t           motor_resp_q[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       ticks_sent   = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  logic [TIME_W-1:0] wall_ms;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic result_t shutter_step(item_t it);
    result_t           r;
    logic              to_open;
    logic              at_target;
    logic              held;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    if (shut_state == ST_UNINIT) begin
      if (it.sw_closed) shut_state = ST_SHUT;
      else if (it.sw_open) shut_state = ST_OPEN;
      else shut_state = ST_HALTED;
    end
    r.motor_cmd = MOTOR_KEEP;
    case (shut_state)
      ST_SHUT: begin
        if (it.req_type == REQ_OPEN) begin
          shut_state = ST_GO_OPEN;
          move_t0 = it.now_ms;
        end
      end
      ST_OPEN: begin
        if (it.req_type == REQ_CLOSE) begin
          shut_state = ST_GO_SHUT;
          move_t0 = it.now_ms;
        end
      end
      ST_HALTED, ST_FAULT: begin
        if (it.req_type == REQ_OPEN) begin
          shut_state = ST_GO_OPEN;
          move_t0 = it.now_ms;
        end else if (it.req_type == REQ_CLOSE) begin
          shut_state = ST_GO_SHUT;
          move_t0 = it.now_ms;
        end
      end
      ST_GO_OPEN, ST_GO_SHUT: begin
        to_open = (shut_state == ST_GO_OPEN);
        if (to_open) begin
          held = (cfg_mode == MODE_INNER) && it.sw_inter;
          at_target = it.sw_open;
        end else begin
          held = (cfg_mode == MODE_OUTER) && !it.sw_inter;
          at_target = it.sw_closed;
        end
        if (held) begin
          r.motor_cmd = MOTOR_BRAKE;
        end else begin
          r.motor_cmd = MOTOR_RUN;
          r.motor_dir = to_open ? DIR_TO_OPEN : DIR_TO_CLOSE;
        end
        elapsed = it.now_ms - move_t0;
        // target, then abort, then timeout
        if (at_target) begin
          shut_state = to_open ? ST_OPEN : ST_SHUT;
          r.motor_cmd = MOTOR_BRAKE;
        end else if (it.req_type == REQ_ABORT) begin
          shut_state = ST_HALTED;
          r.motor_cmd = MOTOR_BRAKE;
        end else if (elapsed > cfg_timeout) begin
          shut_state = ST_FAULT;
          r.motor_cmd = MOTOR_BRAKE;
        end
        if (r.motor_cmd != MOTOR_RUN) r.motor_dir = 1'b0;
      end
      default: ;
    endcase
    r.shutter_state = shut_state;
    return r;
  endfunction

  task automatic send_tick(input req_e req, input logic closed, input logic opened,
                           input logic inter, input logic [TIME_W-1:0] now);
    item_t       it;
    int unsigned gap;
    it.req_type  = req;
    it.sw_closed = closed;
    it.sw_open   = opened;
    it.sw_inter  = inter;
    it.now_ms    = now;
    tick_if.valid     <= 1'b1;
    tick_if.req_type  <= it.req_type;
    tick_if.sw_closed <= closed;
    tick_if.sw_open   <= opened;
    tick_if.sw_inter  <= inter;
    tick_if.now_ms    <= now;
    do @(posedge clk_i); while (!tick_if.ready);
    motor_resp_q.push_back(shutter_step(it));
    ticks_sent++;
    gap = idle_len(send_idle_pct);
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every result is out, then let the pipeline settle
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (motor_resp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [TIME_W-1:0] timeout, input logic [CFG_W-1:0] mode_word);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RUN_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk_i);
    cfg_idx  <= CFG_INTER_MODE;
    cfg_data <= mode_word;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_timeout = timeout;
    cfg_mode = mode_word[1:0];
    @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] time_step();
    if (cfg_timeout < 64) return $urandom_range(cfg_timeout + 2, 0);
    if ($urandom_range(19) == 0) return $urandom();
    return $urandom_range(cfg_timeout / 6, 0);
  endfunction

  // the first tick seeds the state from the switches: open here, then close
  task automatic test_first_tick();
    send_tick(REQ_CLOSE, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFF0);
  endtask

  task automatic test_commands();
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b1, 32'h0000_0010);  // wrapped time
    send_tick(REQ_OPEN,  1'b0, 1'b0, 1'b0, 32'h0000_EA50);  // exactly at timeout
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'h0000_EA51);  // past it
    send_tick(REQ_OPEN,  1'b0, 1'b0, 1'b0, 32'd100);
    send_tick(REQ_ABORT, 1'b1, 1'b1, 1'b1, 32'd101);        // target beats abort
    send_tick(REQ_OPEN,  1'b0, 1'b1, 1'b0, 32'd102);
    send_tick(REQ_ABORT, 1'b0, 1'b1, 1'b0, 32'd103);
    send_tick(REQ_CLOSE, 1'b0, 1'b1, 1'b0, 32'd104);
    send_tick(REQ_ABORT, 1'b0, 1'b0, 1'b0, 32'd105);
    send_tick(REQ_ABORT, 1'b0, 1'b0, 1'b0, 32'd106);
    send_tick(REQ_CLOSE, 1'b0, 1'b0, 1'b0, 32'd107);
    send_tick(REQ_NONE,  1'b1, 1'b0, 1'b0, 32'd108);
    send_tick(REQ_CLOSE, 1'b1, 1'b0, 1'b0, 32'd109);
    send_tick(REQ_OPEN,  1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_interference();
    set_config(32'd60000, {30'd0, MODE_INNER});
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b1, 32'd5);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'd6);
    send_tick(REQ_ABORT, 1'b0, 1'b0, 1'b1, 32'd7);
    send_tick(REQ_CLOSE, 1'b0, 1'b0, 1'b1, 32'd8);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b1, 32'd9);
    // upper data bits must be dropped
    set_config(32'd60000, 32'hFFFF_FFFE);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'd10);
    send_tick(REQ_NONE,  1'b1, 1'b0, 1'b0, 32'd11);
    set_config(32'd60000, 32'd3);
    send_tick(REQ_OPEN,  1'b1, 1'b0, 1'b0, 32'd12);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b1, 32'd13);
  endtask

  task automatic test_timeout_extremes();
    set_config(32'd0, {30'd0, MODE_NONE});
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'd12);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'd13);
    set_config(32'hFFFF_FFFF, {30'd0, MODE_NONE});
    send_tick(REQ_CLOSE, 1'b0, 1'b0, 1'b0, 32'd20);
    send_tick(REQ_NONE,  1'b0, 1'b0, 1'b0, 32'd19);
  endtask

  // start a move, run it for a while, then end it at the target, by abort or by timeout, or leave it running
  task automatic run_motion(input int unsigned n_ticks);
    int unsigned goal;
    int unsigned len;
    int unsigned ending;
    logic        to_open;
    logic        at_target;
    logic        off_sw;
    req_e        req;
    goal = ticks_sent + n_ticks;
    while (ticks_sent < goal) begin
      if ($urandom_range(99) < 12) begin
        wall_ms = ($urandom_range(3) == 0) ? $urandom() : wall_ms + time_step();
        send_tick(req_e'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), wall_ms);
      end else begin
        if (shut_state != ST_GO_OPEN && shut_state != ST_GO_SHUT) begin
          to_open = (shut_state == ST_SHUT) ||
                    (shut_state != ST_OPEN && $urandom_range(1) == 1);
          wall_ms = wall_ms + time_step();
          send_tick(to_open ? REQ_OPEN : REQ_CLOSE, shut_state == ST_SHUT,
                    shut_state == ST_OPEN, 1'($urandom_range(1)), wall_ms);
        end
        to_open = (shut_state == ST_GO_OPEN);
        len = $urandom_range(8, 1);
        ending = $urandom_range(3);
        for (int unsigned k = 0; k < len; k++) begin
          wall_ms = wall_ms + time_step();
          req = ($urandom_range(9) == 0) ? req_e'($urandom_range(3)) : REQ_NONE;
          at_target = 1'b0;
          off_sw = ($urandom_range(3) == 0);
          if (k == len - 1) begin
            case (ending)
              0: at_target = 1'b1;
              1: req = REQ_ABORT;
              2: wall_ms = wall_ms + cfg_timeout + 1 + $urandom_range(3);
              default: ;
            endcase
          end
          send_tick(req, to_open ? off_sw : at_target, to_open ? at_target : off_sw,
                    1'($urandom_range(1)), wall_ms);
        end
      end
    end
  endtask

  task automatic test_random_motion();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(32'd60000, {30'd0, MODE_INNER});
        1: set_config(32'd0, {30'd0, MODE_OUTER});
        2: set_config(32'hFFFF_FFFF, {30'd0, MODE_NONE});
        3: set_config($urandom_range(50, 1), 32'd3);
        4: set_config($urandom(), $urandom());
        default: set_config(32'd1000, {30'd0, MODE_OUTER});
      endcase
      case (p)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 20; recv_idle_pct = 20; end
        2: begin send_idle_pct = 50; recv_idle_pct = 10; end
        3: begin send_idle_pct = 10; recv_idle_pct = 50; end
        4: begin send_idle_pct = 30; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 40; end
      endcase
      run_motion(145);
    end
  endtask

  // downstream stalls
  always @(posedge clk_i) begin : drive_ready
    int unsigned stall_left;
    int unsigned n;
    if (stall_left != 0) begin
      result_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      n = idle_len(recv_idle_pct);
      result_if.ready <= (n == 0);
      stall_left = (n == 0) ? 0 : n - 1;
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t exp;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (motor_resp_q.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatch_cnt++;
      end else begin
        exp = motor_resp_q.pop_front();
        if (result_if.shutter_state !== exp.shutter_state) begin
          $error("shutter_state: expected %0d, got %0d", exp.shutter_state,
                 result_if.shutter_state);
          mismatch_cnt++;
        end
        if (result_if.motor_cmd !== exp.motor_cmd) begin
          $error("motor_cmd: expected %0d, got %0d", exp.motor_cmd, result_if.motor_cmd);
          mismatch_cnt++;
        end
        if (result_if.motor_dir !== exp.motor_dir) begin
          $error("motor_dir: expected %0d, got %0d", exp.motor_dir, result_if.motor_dir);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_RUN_TIMEOUT;
    cfg_data          <= '0;
    tick_if.valid     <= 1'b0;
    tick_if.req_type  <= REQ_NONE;
    tick_if.sw_closed <= 1'b0;
    tick_if.sw_open   <= 1'b0;
    tick_if.sw_inter  <= 1'b0;
    tick_if.now_ms    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_tick();
    test_commands();
    test_interference();
    test_timeout_extremes();
    wall_ms = $urandom();
    test_random_motion();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && motor_resp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
